FILE: sv/pfld_pkg.sv
// Shared types and constants of the packed frame-buffer line-drawing engine.
`default_nettype none

package pfld_pkg;

   localparam int unsigned CMD_W = 2;
   localparam int unsigned LEVEL_W = 4;
   localparam int unsigned ADDR_W = 13;
   localparam int unsigned DATA_W = 8;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [DATA_W-1:0] LOW_NIBBLE = 8'h0F;
   localparam logic [DATA_W-1:0] HIGH_NIBBLE = 8'hF0;

   localparam logic [CMD_W-1:0] CMD_CODE_LINE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CODE_READ = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CODE_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CODE_NONE = 2'd3;

   typedef enum logic [1:0] {
      KIND_LINE,
      KIND_READ,
      KIND_CLEAR,
      KIND_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                step_x_neg;
      logic                step_y_neg;
      logic [LEVEL_W-1:0]  level;
      logic [ADDR_W-1:0]   read_addr;
   } cmd_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic init_active;
   } back_stat_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_LINE_END,
      BK_LINE_STEP,
      BK_READ,
      BK_READ_OUT,
      BK_CLEAR,
      BK_NOP
   } back_state_type;

endpackage

`default_nettype wire

FILE: sv/packed_framebuffer_line_draw.sv
// Top level of the packed 4-bit-per-pixel frame-buffer line-drawing engine.
// Usage:
//   Commands enter on the req_ ports and are taken at a clock edge with req_start
//   high and busy low: 0 draws a line from (start_x, start_y) to (end_x, end_y)
//   at req_level, 1 reads frame byte req_read_addr, 2 clears the frame store,
//   3 does nothing. Every command gives one item on the rsp_ ports, in order,
//   marked by rsp_valid for one cycle; the receiver cannot hold it off.
//   A two-entry queue sits between the command front end and the drawing back
//   end, so up to two commands can wait while one is carried out.
// Cycles per command in the back end, counted from the cycle it leaves the queue:
//   line: N + 3, N = max(|end_x - start_x|, |end_y - start_y|), one pixel a cycle
//   through a read-modify-write on the single frame-store port; read: 3; no-op: 2;
//   clear: FRAME_BYTES + 1, one byte a cycle. A command waits one cycle in the
//   queue at the least.
// Reset: busy stays high for FRAME_BYTES cycles (8192 at the default screen) while
//   the frame store is swept to zero; the queue and back end start empty.
`default_nettype none

module packed_framebuffer_line_draw #(
   parameter int SCREEN_WIDTH = 256,
   parameter int SCREEN_HEIGHT = 64,
   parameter int COORD_BITS = 11
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_start,
   output logic                                    busy,
   input  wire logic [pfld_pkg::CMD_W-1:0]         req_command,
   input  wire logic signed [COORD_BITS-1:0]       req_start_x,
   input  wire logic signed [COORD_BITS-1:0]       req_start_y,
   input  wire logic signed [COORD_BITS-1:0]       req_end_x,
   input  wire logic signed [COORD_BITS-1:0]       req_end_y,
   input  wire logic [pfld_pkg::LEVEL_W-1:0]       req_level,
   input  wire logic [pfld_pkg::ADDR_W-1:0]        req_read_addr,
   output logic                                    rsp_valid,
   output logic [pfld_pkg::DATA_W-1:0]             rsp_read_data,
   output logic                                    rsp_was_read
);

   localparam int GEO_W = 6 * COORD_BITS;

   logic                         push;
   pfld_pkg::cmd_ctl_type        push_ctl;
   logic [GEO_W-1:0]             push_geo;
   pfld_pkg::cmd_ctl_type        head_ctl;
   logic [GEO_W-1:0]             head_geo;
   pfld_pkg::queue_stat_type     q_stat;
   pfld_pkg::back_stat_type      back_stat;
   logic                         q_pop;

   assign busy = q_stat.full || back_stat.init_active;

   pfld_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_start(req_start),
      .busy(busy),
      .req_command(req_command),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_level(req_level),
      .req_read_addr(req_read_addr),
      .push(push),
      .push_ctl(push_ctl),
      .push_geo(push_geo)
   );

   pfld_queue #(
      .GEO_W(GEO_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_ctl(push_ctl),
      .push_geo(push_geo),
      .pop(q_pop),
      .head_ctl(head_ctl),
      .head_geo(head_geo),
      .q_stat(q_stat)
   );

   pfld_back #(
      .SCREEN_WIDTH(SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT),
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(!q_stat.empty),
      .head_ctl(head_ctl),
      .head_geo(head_geo),
      .q_pop(q_pop),
      .back_stat(back_stat),
      .rsp_valid(rsp_valid),
      .rsp_read_data(rsp_read_data),
      .rsp_was_read(rsp_was_read)
   );

   // a nonzero data byte only ever answers a read
   assert property (@(posedge clock) disable iff (reset)
      (rsp_read_data != '0) |-> (rsp_valid && rsp_was_read))
      else $error("read data outside a read response");

   // the store sweep holds commands off right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("command accepted during the reset clear sweep");

   // the back end never takes a new command in the cycle it answers one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_pop)
      else $error("queue pop while a response is out");

endmodule

`default_nettype wire

FILE: sv/pfld_front.sv
// Front end: accepts commands and classifies them into queue entries with line setup.
`default_nettype none

module pfld_front #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                                   req_start,
   input  wire logic                                   busy,
   input  wire logic [pfld_pkg::CMD_W-1:0]             req_command,
   input  wire logic signed [COORD_BITS-1:0]           req_start_x,
   input  wire logic signed [COORD_BITS-1:0]           req_start_y,
   input  wire logic signed [COORD_BITS-1:0]           req_end_x,
   input  wire logic signed [COORD_BITS-1:0]           req_end_y,
   input  wire logic [pfld_pkg::LEVEL_W-1:0]           req_level,
   input  wire logic [pfld_pkg::ADDR_W-1:0]            req_read_addr,
   output logic                                        push,
   output pfld_pkg::cmd_ctl_type                       push_ctl,
   output logic [6*COORD_BITS-1:0]                     push_geo
);

   logic signed [COORD_BITS:0]   diff_x;
   logic signed [COORD_BITS:0]   diff_y;
   logic signed [COORD_BITS:0]   abs_x;
   logic signed [COORD_BITS:0]   abs_y;
   pfld_pkg::cmd_kind_type       kind;

   assign push = req_start && !busy;

   always_comb begin
      unique case (req_command)
         pfld_pkg::CMD_CODE_LINE:  kind = pfld_pkg::KIND_LINE;
         pfld_pkg::CMD_CODE_READ:  kind = pfld_pkg::KIND_READ;
         pfld_pkg::CMD_CODE_CLEAR: kind = pfld_pkg::KIND_CLEAR;
         pfld_pkg::CMD_CODE_NONE:  kind = pfld_pkg::KIND_NONE;
         default:                  kind = pfld_pkg::KIND_NONE;
      endcase
   end

   // widen by one bit so the difference of two extreme coordinates cannot wrap
   always_comb begin
      diff_x = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      diff_y = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      abs_x = diff_x[COORD_BITS] ? -diff_x : diff_x;
      abs_y = diff_y[COORD_BITS] ? -diff_y : diff_y;
   end

   always_comb begin
      push_ctl.kind = kind;
      push_ctl.step_x_neg = !(req_start_x < req_end_x);
      push_ctl.step_y_neg = !(req_start_y < req_end_y);
      push_ctl.level = req_level;
      push_ctl.read_addr = req_read_addr;
      push_geo = {req_start_x, req_start_y, req_end_x, req_end_y,
                  abs_x[COORD_BITS-1:0], abs_y[COORD_BITS-1:0]};
   end

endmodule

`default_nettype wire

FILE: sv/pfld_queue.sv
// Short command queue between the front end and the drawing back end.
`default_nettype none

module pfld_queue #(
   parameter int GEO_W = 66
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire pfld_pkg::cmd_ctl_type    push_ctl,
   input  wire logic [GEO_W-1:0]         push_geo,
   input  wire logic                     pop,
   output pfld_pkg::cmd_ctl_type         head_ctl,
   output logic [GEO_W-1:0]              head_geo,
   output pfld_pkg::queue_stat_type      q_stat
);

   localparam int PTR_W = (pfld_pkg::QUEUE_DEPTH > 1) ? $clog2(pfld_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(pfld_pkg::QUEUE_DEPTH + 1);

   pfld_pkg::cmd_ctl_type  ctl_mem_ff [pfld_pkg::QUEUE_DEPTH];
   logic [GEO_W-1:0]       geo_mem_ff [pfld_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   do_push;
   logic                   do_pop;

   assign do_push = push && (count_ff != CNT_W'(pfld_pkg::QUEUE_DEPTH));
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pfld_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pfld_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_mem_ff[wr_ptr_ff] <= push_ctl;
         geo_mem_ff[wr_ptr_ff] <= push_geo;
      end
   end

   always_comb begin
      head_ctl = ctl_mem_ff[rd_ptr_ff];
      head_geo = geo_mem_ff[rd_ptr_ff];
      q_stat.full = (count_ff == CNT_W'(pfld_pkg::QUEUE_DEPTH));
      q_stat.empty = (count_ff == '0);
   end

endmodule

`default_nettype wire

FILE: sv/pfld_back.sv
// Back end: frame store, Bresenham stepper, byte read-out and clear sweep.
`default_nettype none

module pfld_back #(
   parameter int SCREEN_WIDTH = 256,
   parameter int SCREEN_HEIGHT = 64,
   parameter int COORD_BITS = 11
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire pfld_pkg::cmd_ctl_type           head_ctl,
   input  wire logic [6*COORD_BITS-1:0]         head_geo,
   output logic                                 q_pop,
   output pfld_pkg::back_stat_type              back_stat,
   output logic                                 rsp_valid,
   output logic [pfld_pkg::DATA_W-1:0]          rsp_read_data,
   output logic                                 rsp_was_read
);

   localparam int FRAME_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int IDX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);
   localparam int ERR_W = COORD_BITS + 3;
   localparam int C = COORD_BITS;

   pfld_pkg::back_state_type        state_ff;
   pfld_pkg::back_state_type        state_in;

   logic [pfld_pkg::DATA_W-1:0]     frame_mem_ff [FRAME_BYTES];
   logic [pfld_pkg::DATA_W-1:0]     rd_data_ff;

   logic signed [C-1:0]             cur_x_ff;
   logic signed [C-1:0]             cur_x_in;
   logic signed [C-1:0]             cur_y_ff;
   logic signed [C-1:0]             cur_y_in;
   logic signed [C-1:0]             end_x_ff;
   logic signed [C-1:0]             end_y_ff;
   logic [C-1:0]                    dx_ff;
   logic [C-1:0]                    dy_ff;
   logic                            sx_neg_ff;
   logic                            sy_neg_ff;
   logic [pfld_pkg::LEVEL_W-1:0]    level_ff;
   logic signed [ERR_W-1:0]         err_ff;
   logic signed [ERR_W-1:0]         err_in;
   logic [pfld_pkg::ADDR_W-1:0]     rd_addr_ff;
   logic                            rd_ok_ff;
   logic [AW-1:0]                   clr_idx_ff;
   logic [AW-1:0]                   clr_idx_in;

   logic                            wr_pend_ff;
   logic [AW-1:0]                   wr_addr_ff;
   logic                            wr_odd_ff;
   logic [pfld_pkg::LEVEL_W-1:0]    wr_level_ff;
   logic                            last_valid_ff;
   logic [AW-1:0]                   last_addr_ff;
   logic [pfld_pkg::DATA_W-1:0]     last_data_ff;

   logic signed [C-1:0]             geo_x0;
   logic signed [C-1:0]             geo_y0;
   logic signed [C-1:0]             geo_x1;
   logic signed [C-1:0]             geo_y1;
   logic [C-1:0]                    geo_dx;
   logic [C-1:0]                    geo_dy;

   logic                            at_end;
   logic                            clr_last;
   logic                            clearing;
   logic                            pix_issue;
   logic signed [C-1:0]             pix_x;
   logic signed [C-1:0]             pix_y;
   logic                            on_screen;
   logic [IDX_W-1:0]                lin_idx;
   logic                            pix_ok;
   logic [AW-1:0]                   mem_rd_addr;
   logic                            mem_we;
   logic [AW-1:0]                   mem_wa;
   logic [pfld_pkg::DATA_W-1:0]     mem_wd;
   logic [pfld_pkg::DATA_W-1:0]     base_byte;
   logic [pfld_pkg::DATA_W-1:0]     level_byte;
   logic [pfld_pkg::DATA_W-1:0]     merged_byte;

   logic signed [ERR_W-1:0]         e2;
   logic signed [ERR_W-1:0]         dx_s;
   logic signed [ERR_W-1:0]         dy_s;
   logic signed [ERR_W-1:0]         neg_dy;
   logic signed [ERR_W-1:0]         dx_term;
   logic signed [ERR_W-1:0]         dy_term;
   logic                            move_x;
   logic                            move_y;

   always_comb begin
      geo_x0 = head_geo[6*C-1:5*C];
      geo_y0 = head_geo[5*C-1:4*C];
      geo_x1 = head_geo[4*C-1:3*C];
      geo_y1 = head_geo[3*C-1:2*C];
      geo_dx = head_geo[2*C-1:C];
      geo_dy = head_geo[C-1:0];
   end

   assign at_end = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign clr_last = (clr_idx_ff == AW'(FRAME_BYTES - 1));
   assign clearing = (state_ff == pfld_pkg::BK_INIT) || (state_ff == pfld_pkg::BK_CLEAR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfld_pkg::BK_INIT: begin
            if (clr_last) state_in = pfld_pkg::BK_IDLE;
         end
         pfld_pkg::BK_IDLE: begin
            if (q_valid) begin
               unique case (head_ctl.kind)
                  pfld_pkg::KIND_LINE:  state_in = pfld_pkg::BK_LINE_END;
                  pfld_pkg::KIND_READ:  state_in = pfld_pkg::BK_READ;
                  pfld_pkg::KIND_CLEAR: state_in = pfld_pkg::BK_CLEAR;
                  pfld_pkg::KIND_NONE:  state_in = pfld_pkg::BK_NOP;
                  default:              state_in = pfld_pkg::BK_NOP;
               endcase
            end
         end
         pfld_pkg::BK_LINE_END:  state_in = pfld_pkg::BK_LINE_STEP;
         pfld_pkg::BK_LINE_STEP: begin
            if (at_end) state_in = pfld_pkg::BK_IDLE;
         end
         pfld_pkg::BK_READ:      state_in = pfld_pkg::BK_READ_OUT;
         pfld_pkg::BK_READ_OUT:  state_in = pfld_pkg::BK_IDLE;
         pfld_pkg::BK_CLEAR: begin
            if (clr_last) state_in = pfld_pkg::BK_IDLE;
         end
         pfld_pkg::BK_NOP:       state_in = pfld_pkg::BK_IDLE;
         default:                state_in = pfld_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = (state_ff == pfld_pkg::BK_IDLE) && q_valid;
      back_stat.init_active = (state_ff == pfld_pkg::BK_INIT);
      rsp_valid = ((state_ff == pfld_pkg::BK_LINE_STEP) && at_end)
               || (state_ff == pfld_pkg::BK_READ_OUT)
               || (state_ff == pfld_pkg::BK_NOP)
               || ((state_ff == pfld_pkg::BK_CLEAR) && clr_last);
      rsp_was_read = (state_ff == pfld_pkg::BK_READ_OUT);
      rsp_read_data = ((state_ff == pfld_pkg::BK_READ_OUT) && rd_ok_ff) ? rd_data_ff : '0;
   end

   // pixel issue: the end point first, then the walk from the start point
   always_comb begin
      pix_issue = 1'b0;
      pix_x = cur_x_ff;
      pix_y = cur_y_ff;
      if (state_ff == pfld_pkg::BK_LINE_END) begin
         pix_issue = 1'b1;
         pix_x = end_x_ff;
         pix_y = end_y_ff;
      end else if ((state_ff == pfld_pkg::BK_LINE_STEP) && !at_end) begin
         pix_issue = 1'b1;
      end
   end

   always_comb begin
      on_screen = (int'(pix_x) >= 0) && (int'(pix_x) < SCREEN_WIDTH)
               && (int'(pix_y) >= 0) && (int'(pix_y) < SCREEN_HEIGHT);
      lin_idx = (IDX_W'(unsigned'(pix_x)) >> 1)
              + ((IDX_W'(unsigned'(pix_y)) * IDX_W'(SCREEN_WIDTH)) >> 1);
      pix_ok = on_screen && (lin_idx < IDX_W'(FRAME_BYTES));
      mem_rd_addr = (state_ff == pfld_pkg::BK_READ) ? AW'(rd_addr_ff) : lin_idx[AW-1:0];
   end

   // Bresenham step
   always_comb begin
      dx_s = signed'(ERR_W'(dx_ff));
      dy_s = signed'(ERR_W'(dy_ff));
      neg_dy = -dy_s;
      e2 = err_ff <<< 1;
      move_x = (e2 > neg_dy);
      move_y = (e2 < dx_s);
      dy_term = '0;
      dx_term = '0;
      if (move_x) dy_term = dy_s;
      if (move_y) dx_term = dx_s;
      err_in = err_ff - dy_term + dx_term;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (move_x) begin
         cur_x_in = sx_neg_ff ? cur_x_ff - C'(1) : cur_x_ff + C'(1);
      end
      if (move_y) begin
         cur_y_in = sy_neg_ff ? cur_y_ff - C'(1) : cur_y_ff + C'(1);
      end
   end

   // write stage: forward the byte written last cycle, the memory read missed it
   always_comb begin
      base_byte = (last_valid_ff && (last_addr_ff == wr_addr_ff)) ? last_data_ff : rd_data_ff;
      level_byte = pfld_pkg::DATA_W'(wr_level_ff);
      if (wr_odd_ff) begin
         merged_byte = (level_byte & pfld_pkg::LOW_NIBBLE) | (base_byte & pfld_pkg::HIGH_NIBBLE);
      end else begin
         merged_byte = ((level_byte << 4) & pfld_pkg::HIGH_NIBBLE)
                     | (base_byte & pfld_pkg::LOW_NIBBLE);
      end
      if (clearing) begin
         mem_we = 1'b1;
         mem_wa = clr_idx_ff;
         mem_wd = '0;
      end else begin
         mem_we = wr_pend_ff;
         mem_wa = wr_addr_ff;
         mem_wd = merged_byte;
      end
      clr_idx_in = clr_idx_ff;
      if (clearing) begin
         clr_idx_in = clr_last ? '0 : clr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= frame_mem_ff[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfld_pkg::BK_INIT;
         clr_idx_ff <= '0;
         wr_pend_ff <= 1'b0;
         last_valid_ff <= 1'b0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         err_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         wr_pend_ff <= pix_issue && pix_ok;
         if (mem_we) begin
            last_valid_ff <= 1'b1;
         end
         if (q_pop && (head_ctl.kind == pfld_pkg::KIND_LINE)) begin
            cur_x_ff <= geo_x0;
            cur_y_ff <= geo_y0;
            err_ff <= signed'(ERR_W'(geo_dx)) - signed'(ERR_W'(geo_dy));
         end else if ((state_ff == pfld_pkg::BK_LINE_STEP) && !at_end) begin
            cur_x_ff <= cur_x_in;
            cur_y_ff <= cur_y_in;
            err_ff <= err_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      wr_addr_ff <= lin_idx[AW-1:0];
      wr_odd_ff <= pix_x[0];
      wr_level_ff <= level_ff;
      if (mem_we) begin
         last_addr_ff <= mem_wa;
         last_data_ff <= mem_wd;
      end
      if (q_pop) begin
         end_x_ff <= geo_x1;
         end_y_ff <= geo_y1;
         dx_ff <= geo_dx;
         dy_ff <= geo_dy;
         sx_neg_ff <= head_ctl.step_x_neg;
         sy_neg_ff <= head_ctl.step_y_neg;
         level_ff <= head_ctl.level;
         rd_addr_ff <= head_ctl.read_addr;
      end
      if (state_ff == pfld_pkg::BK_READ) begin
         rd_ok_ff <= (32'(rd_addr_ff) < 32'(FRAME_BYTES));
      end
   end

endmodule

`default_nettype wire
